FILE: rtl/lmcs_pkg.sv
`default_nettype none

package lmcs_pkg;

    typedef enum logic [1:0] {
        OP_SET_PIXEL   = 2'd0,
        OP_REFRESH     = 2'd1,
        OP_PRELOAD     = 2'd2,
        OP_SELECT_LINE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_REFRESH,
        ST_PRELOAD
    } st_t;

    typedef enum logic [1:0] {
        CH_BLUE  = 2'd0,
        CH_GREEN = 2'd1,
        CH_RED   = 2'd2
    } chan_t;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

endpackage

`default_nettype wire

FILE: rtl/lmcs_ram.sv
`default_nettype none

module lmcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/led_matrix_column_serializer_unit.sv
`default_nettype none

// a request waits in a command register; set pixel and select line answer from that register
// set pixel: an in-range pixel then takes three store byte writes; next request accepted after them
// select line: next request accepted once the answer is registered
// refresh column: ROWS*3 store bytes, one per cycle unless out_stall holds the output
// brightness preload: ceil(PRELOAD_BITS/8) bytes, the last one masked to the remaining bits
// reset: asynchronous; then a store clearing pass over all COLUMNS*ROWS*3 entries, requests stalled
module led_matrix_column_serializer_unit
    import lmcs_pkg::*;
#(
    parameter int COLUMNS      = 8,
    parameter int ROWS         = 8,
    parameter int PRELOAD_BITS = 144
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] opcode,
    input  wire logic [2:0] col_x,
    input  wire logic [2:0] row_y,
    input  wire logic [7:0] red_level,
    input  wire logic [7:0] green_level,
    input  wire logic [7:0] blue_level,
    input  wire logic [3:0] line_index,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic      [7:0] shift_byte,
    output logic            shift_valid,
    output logic            image_bank,
    output logic            latch_pulse,
    output logic      [7:0] line_mask,
    output logic            last_item
);

    localparam int DEPTH    = COLUMNS * ROWS * 3;
    localparam int AW       = $clog2(DEPTH);
    localparam int N_RF     = ROWS * 3;
    localparam int CW       = $clog2(N_RF + 1);
    localparam int N_PL     = (PRELOAD_BITS + 7) / 8;
    localparam int PW       = $clog2(N_PL + 1);
    localparam int PL_REM   = PRELOAD_BITS % 8;
    localparam logic [7:0] PL_LAST =
        (PL_REM == 0) ? FULL_BYTE : 8'((32'hFF << (8 - PL_REM)) & 32'hFF);
    localparam logic [4:0] COL_LIM = 5'(COLUMNS);
    localparam logic [4:0] ROW_LIM = 5'(ROWS);

    st_t         state_reg, state_next;
    logic        cmd_valid_reg, cmd_valid_next;
    op_t         cmd_op_reg, cmd_op_next;
    logic [2:0]  cmd_x_reg, cmd_x_next;
    logic [2:0]  cmd_y_reg, cmd_y_next;
    logic [7:0]  cmd_r_reg, cmd_r_next;
    logic [7:0]  cmd_g_reg, cmd_g_next;
    logic [7:0]  cmd_b_reg, cmd_b_next;
    logic [3:0]  cmd_line_reg, cmd_line_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0]  phase_reg, phase_next;
    logic [CW-1:0] rd_cnt_reg, rd_cnt_next;
    logic [CW-1:0] em_cnt_reg, em_cnt_next;
    logic        pend_reg, pend_next;
    logic [PW-1:0] pl_cnt_reg, pl_cnt_next;
    logic [7:0]  lines_reg, lines_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic        shift_valid_reg, shift_valid_next;
    logic        image_bank_reg, image_bank_next;
    logic        latch_reg, latch_next;
    logic [7:0]  line_mask_reg, line_mask_next;
    logic        last_reg, last_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          slot_free;
    logic          in_accept;
    logic          x_ok;
    logic          y_ok;
    logic [AW-1:0] pix_base;
    logic [AW-1:0] col_base;
    logic          rf_load;
    logic          rf_issue;

    lmcs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = cmd_valid_reg || (state_reg == ST_CLEAR);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    assign x_ok     = {2'b00, cmd_x_reg} < COL_LIM;
    assign y_ok     = {2'b00, cmd_y_reg} < ROW_LIM;
    assign pix_base = AW'((int'(cmd_x_reg) * ROWS + int'(cmd_y_reg)) * 3);
    assign col_base = AW'(int'(cmd_x_reg) * N_RF);

    assign rf_load  = (state_reg == ST_REFRESH) && pend_reg && slot_free;
    assign rf_issue = (state_reg == ST_REFRESH) && (rd_cnt_reg < CW'(N_RF))
                      && (!pend_reg || rf_load);

    assign out_valid   = out_valid_reg;
    assign shift_byte  = shift_byte_reg;
    assign shift_valid = shift_valid_reg;
    assign image_bank  = image_bank_reg;
    assign latch_pulse = latch_reg;
    assign line_mask   = line_mask_reg;
    assign last_item   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cmd_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            phase_reg     <= '0;
            rd_cnt_reg    <= '0;
            em_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            pl_cnt_reg    <= '0;
            lines_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_valid_reg <= cmd_valid_next;
            clr_cnt_reg   <= clr_cnt_next;
            phase_reg     <= phase_next;
            rd_cnt_reg    <= rd_cnt_next;
            em_cnt_reg    <= em_cnt_next;
            pend_reg      <= pend_next;
            pl_cnt_reg    <= pl_cnt_next;
            lines_reg     <= lines_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_op_reg      <= cmd_op_next;
        cmd_x_reg       <= cmd_x_next;
        cmd_y_reg       <= cmd_y_next;
        cmd_r_reg       <= cmd_r_next;
        cmd_g_reg       <= cmd_g_next;
        cmd_b_reg       <= cmd_b_next;
        cmd_line_reg    <= cmd_line_next;
        shift_byte_reg  <= shift_byte_next;
        shift_valid_reg <= shift_valid_next;
        image_bank_reg  <= image_bank_next;
        latch_reg       <= latch_next;
        line_mask_reg   <= line_mask_next;
        last_reg        <= last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_valid_next   = cmd_valid_reg;
        cmd_op_next      = cmd_op_reg;
        cmd_x_next       = cmd_x_reg;
        cmd_y_next       = cmd_y_reg;
        cmd_r_next       = cmd_r_reg;
        cmd_g_next       = cmd_g_reg;
        cmd_b_next       = cmd_b_reg;
        cmd_line_next    = cmd_line_reg;
        clr_cnt_next     = clr_cnt_reg;
        phase_next       = phase_reg;
        rd_cnt_next      = rd_cnt_reg;
        em_cnt_next      = em_cnt_reg;
        pend_next        = pend_reg;
        pl_cnt_next      = pl_cnt_reg;
        lines_next       = lines_reg;
        out_valid_next   = out_valid_reg && out_stall;
        shift_byte_next  = shift_byte_reg;
        shift_valid_next = shift_valid_reg;
        image_bank_next  = image_bank_reg;
        latch_next       = latch_reg;
        line_mask_next   = line_mask_reg;
        last_next        = last_reg;
        ram_we           = 1'b0;
        ram_waddr        = clr_cnt_reg;
        ram_wdata        = '0;
        ram_re           = rf_issue;
        ram_raddr        = AW'(col_base + AW'(rd_cnt_reg));

        if (in_accept)
        begin
            cmd_valid_next = 1'b1;
            cmd_op_next    = op_t'(opcode);
            cmd_x_next     = col_x;
            cmd_y_next     = row_y;
            cmd_r_next     = red_level;
            cmd_g_next     = green_level;
            cmd_b_next     = blue_level;
            cmd_line_next  = line_index;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid_reg)
                begin
                    unique case (cmd_op_reg) inside
                        OP_SET_PIXEL, OP_SELECT_LINE:
                        begin
                            if (slot_free)
                            begin
                                if (cmd_op_reg == OP_SELECT_LINE)
                                begin
                                    lines_next = cmd_line_reg[3] ? 8'h00
                                               : 8'(8'h01 << cmd_line_reg[2:0]);
                                end
                                out_valid_next   = 1'b1;
                                shift_byte_next  = '0;
                                shift_valid_next = 1'b0;
                                image_bank_next  = 1'b0;
                                latch_next       = 1'b0;
                                last_next        = 1'b1;
                                line_mask_next   = (cmd_op_reg == OP_SELECT_LINE)
                                                 ? lines_next : lines_reg;
                                if ((cmd_op_reg == OP_SET_PIXEL) && x_ok && y_ok)
                                begin
                                    phase_next = CH_BLUE;
                                    state_next = ST_WRITE;
                                end
                                else
                                begin
                                    cmd_valid_next = 1'b0;
                                end
                            end
                        end
                        OP_REFRESH:
                        begin
                            if (x_ok)
                            begin
                                rd_cnt_next = '0;
                                em_cnt_next = '0;
                                pend_next   = 1'b0;
                                state_next  = ST_REFRESH;
                            end
                            else if (slot_free)
                            begin
                                out_valid_next   = 1'b1;
                                shift_byte_next  = '0;
                                shift_valid_next = 1'b0;
                                image_bank_next  = 1'b0;
                                latch_next       = 1'b0;
                                last_next        = 1'b1;
                                line_mask_next   = lines_reg;
                                cmd_valid_next   = 1'b0;
                            end
                        end
                        OP_PRELOAD:
                        begin
                            pl_cnt_next = '0;
                            state_next  = ST_PRELOAD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(pix_base + AW'(phase_reg));
                phase_next = phase_reg + 1'b1;
                case (phase_reg)
                    CH_BLUE:  ram_wdata = cmd_b_reg;
                    CH_GREEN: ram_wdata = cmd_g_reg;
                    default:  ram_wdata = cmd_r_reg;
                endcase
                if (phase_reg == CH_RED)
                begin
                    cmd_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_REFRESH:
            begin
                if (rf_issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else if (rf_load)
                begin
                    pend_next = 1'b0;
                end
                if (rf_load)
                begin
                    out_valid_next   = 1'b1;
                    shift_byte_next  = ram_rdata;
                    shift_valid_next = 1'b1;
                    image_bank_next  = 1'b1;
                    latch_next       = (em_cnt_reg == CW'(N_RF - 1));
                    last_next        = (em_cnt_reg == CW'(N_RF - 1));
                    line_mask_next   = lines_reg;
                    em_cnt_next      = em_cnt_reg + 1'b1;
                    if (em_cnt_reg == CW'(N_RF - 1))
                    begin
                        cmd_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_PRELOAD:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    shift_valid_next = 1'b1;
                    image_bank_next  = 1'b0;
                    latch_next       = 1'b0;
                    line_mask_next   = lines_reg;
                    pl_cnt_next      = pl_cnt_reg + 1'b1;
                    if (pl_cnt_reg == PW'(N_PL - 1))
                    begin
                        shift_byte_next = PL_LAST;
                        last_next       = 1'b1;
                        cmd_valid_next  = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        shift_byte_next = FULL_BYTE;
                        last_next       = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
